// ----- hw/rtl/p2pmh_pkg.sv -----
// Package for the message header parser.
// Holds header layout constants, status codes and register indexes.
// No dependencies.
package p2pmh_pkg;

  localparam int POS_W     = 5;
  localparam int CMD_BYTES = 12;
  localparam int CMD_W     = CMD_BYTES * 8;

  typedef logic [POS_W-1:0] pos_t;
  typedef logic [2:0]       status_t;
  typedef logic [3:0]       offset_t;
  typedef logic [0:0]       reg_index_t;

  localparam pos_t HEADER_LAST = 5'd23;
  localparam pos_t CMD_START   = 5'd4;
  localparam pos_t LEN_START   = 5'd16;
  localparam pos_t SUM_START   = 5'd20;

  localparam logic [7:0] CHAR_LO = 8'h20;
  localparam logic [7:0] CHAR_HI = 8'h7E;

  localparam status_t ST_OK        = 3'd0;
  localparam status_t ST_SHORT     = 3'd1;
  localparam status_t ST_MAGIC     = 3'd2;
  localparam status_t ST_AFTER_PAD = 3'd3;
  localparam status_t ST_BAD_CHAR  = 3'd4;
  localparam status_t ST_EMPTY     = 3'd5;
  localparam status_t ST_LARGE     = 3'd6;

  localparam reg_index_t REG_EXPECTED_MAGIC = 1'b0;
  localparam reg_index_t REG_MAX_PAYLOAD    = 1'b1;

  localparam logic [31:0] MAGIC_RESET       = 32'h4654_4321;
  localparam logic [31:0] MAX_PAYLOAD_RESET = 32'h0200_0000;

endpackage

// ----- hw/rtl/p2pmh_ifs.sv -----
// Channel interfaces of the message header parser: header bytes in,
// parsed results out, register writes. Depends on p2pmh_pkg.
interface p2pmh_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last;

  modport source (output valid, data_byte, last, input ready);
  modport sink (input valid, data_byte, last, output ready);
endinterface

interface p2pmh_out_if;
  logic                  valid;
  logic                  ready;
  p2pmh_pkg::status_t    status;
  p2pmh_pkg::offset_t    error_offset;
  logic [31:0]           magic_seen;
  logic [63:0]           command_low;
  logic [31:0]           command_high;
  logic [31:0]           payload_length;
  logic [31:0]           checksum_field;

  modport source (output valid, status, error_offset, magic_seen, command_low,
                  command_high, payload_length, checksum_field, input ready);
  modport sink (input valid, status, error_offset, magic_seen, command_low,
                command_high, payload_length, checksum_field, output ready);
endinterface

interface p2pmh_cfg_if;
  logic                  valid;
  logic                  ready;
  p2pmh_pkg::reg_index_t index;
  logic [31:0]           data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- hw/rtl/p2p_message_header_parser.sv -----
// Message header parser top level: checks magic, command, payload length.
// Depends on p2pmh_pkg and the channel interfaces in p2pmh_ifs.sv.
//
//   channel  role    payload
//   hdr      sink    data_byte, last
//   res      source  status, error_offset, header fields
//   cfg      sink    index, data (register write, always ready)
//
// One byte per cycle unless hdr stalls (see below); a result is registered
// in the cycle after its byte. Reset (rst, synchronous) clears position,
// flags and drain state and restores both registers to their defaults.
// hdr stalls only while a result waits in the output register and res.ready
// is low; the output register refills in the same cycle it is taken.
module p2p_message_header_parser (
  input  logic         clk,
  input  logic         rst,
  p2pmh_in_if.sink     hdr,
  p2pmh_out_if.source  res,
  p2pmh_cfg_if.sink    cfg
);

  logic [31:0] expected_magic;
  logic [31:0] max_payload_bytes;

  p2pmh_pkg::pos_t    pos, pos_next;
  logic               seen_null, seen_null_next;
  logic               seen_content, seen_content_next;
  p2pmh_pkg::status_t first_error, first_error_next;
  p2pmh_pkg::offset_t first_error_offset, first_error_offset_next;
  logic               draining, draining_next;

  logic [31:0]                   magic_shift, magic_shift_next;
  logic [p2pmh_pkg::CMD_W-1:0]   command_shift, command_shift_next;
  logic [31:0]                   length_shift, length_shift_next;
  logic [31:0]                   checksum_shift, checksum_shift_next;

  logic               res_valid;
  p2pmh_pkg::status_t res_status, status_next;
  p2pmh_pkg::offset_t res_offset, offset_next;
  logic [31:0]        res_magic;
  logic [p2pmh_pkg::CMD_W-1:0] res_command;
  logic [31:0]        res_length;
  logic [31:0]        res_checksum;

  logic               hdr_take;
  logic               emit, emit_short;
  logic [7:0]         b;
  p2pmh_pkg::pos_t    cmd_rel;

  assign hdr.ready = !res_valid || res.ready;
  assign hdr_take  = hdr.valid && hdr.ready;
  assign cfg.ready = 1'b1;
  assign b         = hdr.data_byte;
  assign cmd_rel   = pos - p2pmh_pkg::CMD_START;

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_magic    <= p2pmh_pkg::MAGIC_RESET;
      max_payload_bytes <= p2pmh_pkg::MAX_PAYLOAD_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        p2pmh_pkg::REG_EXPECTED_MAGIC: expected_magic    <= cfg.data;
        p2pmh_pkg::REG_MAX_PAYLOAD:    max_payload_bytes <= cfg.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    pos_next                = pos;
    seen_null_next          = seen_null;
    seen_content_next       = seen_content;
    first_error_next        = first_error;
    first_error_offset_next = first_error_offset;
    draining_next           = draining;
    magic_shift_next        = magic_shift;
    command_shift_next      = command_shift;
    length_shift_next       = length_shift;
    checksum_shift_next     = checksum_shift;
    emit                    = 1'b0;
    emit_short              = 1'b0;
    status_next             = p2pmh_pkg::ST_OK;
    offset_next             = '0;

    if (hdr_take) begin
      if (draining) begin
        if (hdr.last) begin
          draining_next = 1'b0;
        end
      end else begin
        if (pos < p2pmh_pkg::CMD_START) begin
          magic_shift_next = {b, magic_shift[31:8]};
        end else if (pos < p2pmh_pkg::LEN_START) begin
          command_shift_next = {b, command_shift[p2pmh_pkg::CMD_W-1:8]};
          if (seen_null) begin
            if (b != 8'd0 && first_error == p2pmh_pkg::ST_OK) begin
              first_error_next        = p2pmh_pkg::ST_AFTER_PAD;
              first_error_offset_next = cmd_rel[3:0];
            end
          end else if (b == 8'd0) begin
            seen_null_next = 1'b1;
          end else if (b < p2pmh_pkg::CHAR_LO || b > p2pmh_pkg::CHAR_HI) begin
            if (first_error == p2pmh_pkg::ST_OK) begin
              first_error_next        = p2pmh_pkg::ST_BAD_CHAR;
              first_error_offset_next = cmd_rel[3:0];
            end
          end else begin
            seen_content_next = 1'b1;
          end
        end else if (pos < p2pmh_pkg::SUM_START) begin
          length_shift_next = {b, length_shift[31:8]};
        end else begin
          checksum_shift_next = {b, checksum_shift[31:8]};
        end

        if (pos != p2pmh_pkg::HEADER_LAST) begin
          pos_next = pos + 1'b1;
          if (hdr.last) begin
            emit        = 1'b1;
            emit_short  = 1'b1;
            status_next = p2pmh_pkg::ST_SHORT;
          end
        end else begin
          emit          = 1'b1;
          draining_next = !hdr.last;
          if (magic_shift != expected_magic) begin
            status_next = p2pmh_pkg::ST_MAGIC;
          end else if (first_error != p2pmh_pkg::ST_OK) begin
            status_next = first_error;
            offset_next = first_error_offset;
          end else if (!seen_content) begin
            status_next = p2pmh_pkg::ST_EMPTY;
          end else if (length_shift > max_payload_bytes) begin
            status_next = p2pmh_pkg::ST_LARGE;
          end
        end

        if (emit) begin
          pos_next                = '0;
          seen_null_next          = 1'b0;
          seen_content_next       = 1'b0;
          first_error_next        = p2pmh_pkg::ST_OK;
          first_error_offset_next = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos                <= '0;
      seen_null          <= 1'b0;
      seen_content       <= 1'b0;
      first_error        <= p2pmh_pkg::ST_OK;
      first_error_offset <= '0;
      draining           <= 1'b0;
      res_valid          <= 1'b0;
    end else begin
      pos                <= pos_next;
      seen_null          <= seen_null_next;
      seen_content       <= seen_content_next;
      first_error        <= first_error_next;
      first_error_offset <= first_error_offset_next;
      draining           <= draining_next;
      if (emit) begin
        res_valid <= 1'b1;
      end else if (res.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    magic_shift    <= magic_shift_next;
    command_shift  <= command_shift_next;
    length_shift   <= length_shift_next;
    checksum_shift <= checksum_shift_next;
    if (emit) begin
      res_status <= status_next;
      res_offset <= offset_next;
      if (emit_short) begin
        res_magic    <= '0;
        res_command  <= '0;
        res_length   <= '0;
        res_checksum <= '0;
      end else begin
        res_magic    <= magic_shift;
        res_command  <= command_shift;
        res_length   <= length_shift;
        res_checksum <= checksum_shift_next;
      end
    end
  end

  assign res.valid          = res_valid;
  assign res.status         = res_status;
  assign res.error_offset   = res_offset;
  assign res.magic_seen     = res_magic;
  assign res.command_low    = res_command[63:0];
  assign res.command_high   = res_command[p2pmh_pkg::CMD_W-1:64];
  assign res.payload_length = res_length;
  assign res.checksum_field = res_checksum;

endmodule

// ----- tb/sv/p2p_message_header_parser_tb.sv -----
// Testbench for p2p_message_header_parser: byte-level header stimulus, self-checking
// against an in-bench header decoder, with random input gaps and output stalls.
// Depends on p2pmh_pkg, the channel interfaces in p2pmh_ifs.sv and the parser RTL.
module p2p_message_header_parser_tb;

  localparam int QUIET_LIMIT   = 5000;
  localparam int HOLD_CYCLES   = 250;
  localparam int HOLD_AT       = 5;
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_BUFS   = 1;

  localparam logic [31:0] DEF_MAGIC   = p2pmh_pkg::MAGIC_RESET;
  localparam logic [31:0] DEF_MAX_LEN = p2pmh_pkg::MAX_PAYLOAD_RESET;

  typedef struct packed {
    logic [7:0] data;
    logic       is_last;
  } hdr_byte_t;

  typedef struct {
    p2pmh_pkg::status_t status;
    p2pmh_pkg::offset_t offset;
    logic [31:0]        magic;
    logic [63:0]        cmd_low;
    logic [31:0]        cmd_high;
    logic [31:0]        length;
    logic [31:0]        checksum;
  } header_result_t;

  logic clk;
  logic rst;

  p2pmh_in_if  hdr ();
  p2pmh_out_if res ();
  p2pmh_cfg_if cfg ();

  p2p_message_header_parser uut (
    .clk (clk),
    .rst (rst),
    .hdr (hdr),
    .res (res),
    .cfg (cfg)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  hdr_byte_t      pending_bytes[$];
  header_result_t expected_results[$];

  logic [31:0] cfg_magic;
  logic [31:0] cfg_max_len;

  p2pmh_pkg::pos_t    prs_pos;
  logic [31:0]        prs_magic;
  logic [7:0]         prs_cmd [p2pmh_pkg::CMD_BYTES];
  logic [31:0]        prs_length;
  logic [31:0]        prs_checksum;
  logic               prs_null_seen;
  logic               prs_text_seen;
  p2pmh_pkg::status_t prs_err;
  p2pmh_pkg::offset_t prs_err_off;
  logic               prs_skip_tail;

  int mismatches;
  int bytes_queued;
  int bytes_taken;
  int buffers_sent;
  int short_sent;
  int results_checked;
  int settings_used;

  function automatic void restart_parse();
    prs_pos       = '0;
    prs_magic     = '0;
    for (int i = 0; i < p2pmh_pkg::CMD_BYTES; i++) prs_cmd[i] = '0;
    prs_length    = '0;
    prs_checksum  = '0;
    prs_null_seen = 1'b0;
    prs_text_seen = 1'b0;
    prs_err       = p2pmh_pkg::ST_OK;
    prs_err_off   = '0;
    prs_skip_tail = 1'b0;
  endfunction

  function automatic void parse_byte(input logic [7:0] b, input logic is_last);
    header_result_t     r;
    p2pmh_pkg::offset_t idx;
    if (prs_skip_tail) begin
      if (is_last) restart_parse();
      return;
    end
    if (prs_pos < p2pmh_pkg::CMD_START) begin
      prs_magic = {b, prs_magic[31:8]};
    end else if (prs_pos < p2pmh_pkg::LEN_START) begin
      idx = p2pmh_pkg::offset_t'(prs_pos - p2pmh_pkg::CMD_START);
      prs_cmd[idx] = b;
      if (prs_null_seen) begin
        if (b != 8'h00 && prs_err == p2pmh_pkg::ST_OK) begin
          prs_err     = p2pmh_pkg::ST_AFTER_PAD;
          prs_err_off = idx;
        end
      end else if (b == 8'h00) begin
        prs_null_seen = 1'b1;
      end else if (b < p2pmh_pkg::CHAR_LO || b > p2pmh_pkg::CHAR_HI) begin
        if (prs_err == p2pmh_pkg::ST_OK) begin
          prs_err     = p2pmh_pkg::ST_BAD_CHAR;
          prs_err_off = idx;
        end
      end else begin
        prs_text_seen = 1'b1;
      end
    end else if (prs_pos < p2pmh_pkg::SUM_START) begin
      prs_length = {b, prs_length[31:8]};
    end else begin
      prs_checksum = {b, prs_checksum[31:8]};
    end

    if (prs_pos != p2pmh_pkg::HEADER_LAST) begin
      if (is_last) begin
        r = '{status: p2pmh_pkg::ST_SHORT, offset: '0, magic: '0, cmd_low: '0,
              cmd_high: '0, length: '0, checksum: '0};
        expected_results.push_back(r);
        restart_parse();
      end else begin
        prs_pos = prs_pos + 1'b1;
      end
      return;
    end

    for (int i = 0; i < 8; i++) r.cmd_low[8*i +: 8] = prs_cmd[i];
    for (int i = 8; i < p2pmh_pkg::CMD_BYTES; i++) r.cmd_high[8*(i-8) +: 8] = prs_cmd[i];
    r.offset   = '0;
    r.magic    = prs_magic;
    r.length   = prs_length;
    r.checksum = prs_checksum;
    if (prs_magic != cfg_magic) begin
      r.status = p2pmh_pkg::ST_MAGIC;
    end else if (prs_err != p2pmh_pkg::ST_OK) begin
      r.status = prs_err;
      r.offset = prs_err_off;
    end else if (!prs_text_seen) begin
      r.status = p2pmh_pkg::ST_EMPTY;
    end else if (prs_length > cfg_max_len) begin
      r.status = p2pmh_pkg::ST_LARGE;
    end else begin
      r.status = p2pmh_pkg::ST_OK;
    end
    expected_results.push_back(r);
    restart_parse();
    if (!is_last) prs_skip_tail = 1'b1;
  endfunction

  function automatic void report_field(input string field, input logic [63:0] want,
                                       input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
      mismatches++;
    end
  endfunction

  function automatic void check_result();
    header_result_t want;
    if (expected_results.size() == 0) begin
      $display("%0t: result with none expected, expected nothing, actual status %0d",
               $time, res.status);
      mismatches++;
      return;
    end
    want = expected_results.pop_front();
    results_checked++;
    report_field("status", want.status, res.status);
    report_field("error_offset", want.offset, res.error_offset);
    report_field("magic_seen", want.magic, res.magic_seen);
    report_field("command_low", want.cmd_low, res.command_low);
    report_field("command_high", want.cmd_high, res.command_high);
    report_field("payload_length", want.length, res.payload_length);
    report_field("checksum_field", want.checksum, res.checksum_field);
  endfunction

  always @(posedge clk) begin
    if (!rst) begin
      if (hdr.valid && hdr.ready) begin
        parse_byte(hdr.data_byte, hdr.last);
        bytes_taken++;
      end
      if (res.valid && res.ready) check_result();
    end
  end

  int        burst_left;
  int        gap_left;
  hdr_byte_t send_byte;

  always @(posedge clk) begin
    if (rst) begin
      hdr.valid <= 1'b0;
      burst_left = $urandom_range(0, 40);
      gap_left   = 0;
    end else if (!hdr.valid || hdr.ready) begin
      if (gap_left > 0) begin
        gap_left--;
        hdr.valid <= 1'b0;
      end else if (pending_bytes.size() != 0) begin
        send_byte = pending_bytes.pop_front();
        hdr.valid     <= 1'b1;
        hdr.data_byte <= send_byte.data;
        hdr.last      <= send_byte.is_last;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 40);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        hdr.valid <= 1'b0;
      end
    end
  end

  int rx_cycle;
  int rx_taken;
  int hold_left;
  bit hold_done;

  always @(posedge clk) begin
    if (rst) begin
      res.ready <= 1'b0;
      rx_cycle  = 0;
      rx_taken  = 0;
      hold_left = 0;
      hold_done = 1'b0;
    end else begin
      rx_cycle++;
      if (res.valid && res.ready) rx_taken++;
      if (hold_left > 0) begin
        hold_left--;
        res.ready <= 1'b0;
      end else if (rx_taken == HOLD_AT && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        res.ready <= 1'b0;
      end else begin
        case ((rx_cycle / 150) % 3)
          0: begin
            res.ready <= 1'b1;
          end
          1: begin
            res.ready <= ($urandom_range(0, 3) != 0);
          end
          default: begin
            res.ready <= ($urandom_range(0, 3) == 0);
          end
        endcase
      end
    end
  end

  int quiet_cycles;

  always @(posedge clk) begin
    if (rst || (hdr.valid && hdr.ready) || (res.valid && res.ready) ||
        (cfg.valid && cfg.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: timeout, no transaction for %0d cycles", $time, QUIET_LIMIT);
      $display("FAILED: results differ");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [p2pmh_pkg::CMD_W-1:0] text_cmd(input string s);
    logic [p2pmh_pkg::CMD_W-1:0] c;
    c = '0;
    for (int i = 0; i < s.len() && i < p2pmh_pkg::CMD_BYTES; i++) c[8*i +: 8] = s[i];
    return c;
  endfunction

  task automatic push_buffer(input logic [31:0] magic,
                             input logic [p2pmh_pkg::CMD_W-1:0] cmd,
                             input logic [31:0] len, input logic [31:0] sum,
                             input int cut, input int extra);
    logic [7:0] hb [24];
    int         total;
    hdr_byte_t  item;
    for (int i = 0; i < 4; i++) begin
      hb[i]      = magic[8*i +: 8];
      hb[16 + i] = len[8*i +: 8];
      hb[20 + i] = sum[8*i +: 8];
    end
    for (int i = 0; i < p2pmh_pkg::CMD_BYTES; i++) hb[4 + i] = cmd[8*i +: 8];
    total = (cut < 24) ? cut : 24 + extra;
    for (int i = 0; i < total; i++) begin
      item.data    = (i < 24) ? hb[i] : 8'($urandom());
      item.is_last = (i == total - 1);
      pending_bytes.push_back(item);
      bytes_queued++;
    end
    buffers_sent++;
    if (cut < 24) short_sent++;
  endtask

  task automatic run_directed();
    logic [p2pmh_pkg::CMD_W-1:0] c;
    push_buffer(DEF_MAGIC, text_cmd("version"), 32'd0, 32'hFFFF_FFFF, 24, 0);
    push_buffer(DEF_MAGIC, text_cmd(" ~~~~~~~~~~~"), DEF_MAX_LEN, 32'd0, 24, 0);
    push_buffer(32'hFFFF_FFFF, text_cmd("ping"), 32'd0, 32'd0, 24, 0);
    c = text_cmd("tx");
    c[7:0] = 8'h1F;
    push_buffer(~DEF_MAGIC, c, 32'd5, 32'h1234_5678, 24, 0);
    push_buffer(DEF_MAGIC, c, 32'd5, 32'h1234_5678, 24, 0);
    c = text_cmd("abcdefghijk");
    c[95:88] = 8'h7F;
    push_buffer(DEF_MAGIC, c, 32'd100, 32'hA5A5_5A5A, 24, 0);
    c = text_cmd("inv");
    c[47:40] = 8'h80;
    c[79:72] = 8'hFF;
    push_buffer(DEF_MAGIC, c, 32'd7, 32'd1, 24, 0);
    c = text_cmd("ab");
    c[31:24] = "c";
    push_buffer(DEF_MAGIC, c, 32'd7, 32'd2, 24, 0);
    c = text_cmd("a");
    c[15:8]  = 8'h01;
    c[31:24] = "z";
    push_buffer(DEF_MAGIC, c, 32'd7, 32'd3, 24, 0);
    c = text_cmd("a");
    c[23:16] = 8'h05;
    push_buffer(DEF_MAGIC, c, 32'd7, 32'd4, 24, 0);
    c = '0;
    c[15:8] = "x";
    push_buffer(DEF_MAGIC, c, 32'd7, 32'd5, 24, 0);
    push_buffer(DEF_MAGIC, '0, 32'd9, 32'd6, 24, 0);
    push_buffer(DEF_MAGIC, '0, 32'hFFFF_FFFF, 32'd7, 24, 0);
    push_buffer(DEF_MAGIC, text_cmd("block"), DEF_MAX_LEN + 32'd1, 32'd8, 24, 0);
    c = text_cmd("getdata");
    c[15:8] = 8'hFE;
    push_buffer(DEF_MAGIC, c, 32'hFFFF_FFFF, 32'd9, 24, 0);
    push_buffer(DEF_MAGIC, text_cmd("inv"), 32'd1, 32'd10, 1, 0);
    push_buffer(DEF_MAGIC, text_cmd("inv"), 32'd1, 32'd11, 10, 0);
    push_buffer(DEF_MAGIC, text_cmd("inv"), 32'd1, 32'd12, 23, 0);
    push_buffer(DEF_MAGIC, text_cmd("headers"), 32'd64, 32'd13, 24, 3);
  endtask

  task automatic push_random_buffer();
    logic [p2pmh_pkg::CMD_W-1:0] c;
    logic [31:0]                 magic;
    logic [31:0]                 len;
    int                          pick;
    int                          n;
    int                          p;
    int                          cut;
    int                          extra;
    pick = $urandom_range(0, 99);
    if (pick < 85) magic = cfg_magic;
    else if (pick < 93) magic = cfg_magic ^ (32'h1 << $urandom_range(0, 31));
    else magic = $urandom();

    pick = $urandom_range(0, 99);
    n = (pick >= 80 && pick < 92) ? $urandom_range(0, 10) : $urandom_range(1, 12);
    c = '0;
    for (int i = 0; i < n; i++) begin
      c[8*i +: 8] = 8'($urandom_range(p2pmh_pkg::CHAR_LO, p2pmh_pkg::CHAR_HI));
    end
    if (pick >= 55 && pick < 65) begin
      c = '0;
    end else if (pick >= 65 && pick < 80) begin
      p = $urandom_range(0, n - 1);
      c[8*p +: 8] = ($urandom_range(0, 1) != 0) ? 8'($urandom_range(1, 8'h1F)) :
                                                  8'($urandom_range(8'h7F, 8'hFF));
    end else if (pick >= 80 && pick < 92) begin
      p = $urandom_range(n + 1, p2pmh_pkg::CMD_BYTES - 1);
      c[8*p +: 8] = 8'($urandom_range(1, 255));
    end else if (pick >= 92) begin
      c = {$urandom(), $urandom(), $urandom()};
    end

    pick = $urandom_range(0, 99);
    if (pick < 40) len = $urandom_range(0, cfg_max_len);
    else if (pick < 55) len = cfg_max_len;
    else if (pick < 70) len = cfg_max_len + 32'd1;
    else len = $urandom();

    cut   = ($urandom_range(0, 99) < 10) ? $urandom_range(1, 23) : 24;
    extra = ($urandom_range(0, 99) < 70) ? 0 : $urandom_range(1, 4);
    push_buffer(magic, c, len, $urandom(), cut, extra);
  endtask

  task automatic write_registers(input logic [31:0] magic, input logic [31:0] max_len);
    cfg.valid <= 1'b1;
    cfg.index <= p2pmh_pkg::REG_EXPECTED_MAGIC;
    cfg.data  <= magic;
    do @(posedge clk); while (!cfg.ready);
    cfg_magic = magic;
    cfg.index <= p2pmh_pkg::REG_MAX_PAYLOAD;
    cfg.data  <= max_len;
    do @(posedge clk); while (!cfg.ready);
    cfg_max_len = max_len;
    cfg.valid <= 1'b0;
    settings_used++;
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (bytes_taken != bytes_queued || expected_results.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    logic [31:0] set_magic;
    logic [31:0] set_max;
    rst           = 1'b1;
    hdr.valid     = 1'b0;
    hdr.data_byte = '0;
    hdr.last      = 1'b0;
    res.ready     = 1'b0;
    cfg.valid     = 1'b0;
    cfg.index     = p2pmh_pkg::REG_EXPECTED_MAGIC;
    cfg.data      = '0;
    cfg_magic     = DEF_MAGIC;
    cfg_max_len   = DEF_MAX_LEN;
    restart_parse();
    mismatches      = 0;
    bytes_queued    = 0;
    bytes_taken     = 0;
    buffers_sent    = 0;
    short_sent      = 0;
    results_checked = 0;
    settings_used   = 1;

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    run_directed();
    wait_drained();

    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin
          set_magic = 32'h0;
          set_max   = 32'h0;
        end
        1: begin
          set_magic = 32'hFFFF_FFFF;
          set_max   = 32'hFFFF_FFFF;
        end
        2: begin
          set_magic = $urandom();
          set_max   = $urandom();
        end
        3: begin
          set_magic = $urandom();
          set_max   = $urandom_range(0, 1000);
        end
        default: begin
          set_magic = DEF_MAGIC;
          set_max   = DEF_MAX_LEN;
        end
      endcase
      write_registers(set_magic, set_max);
      for (int i = 0; i < RANDOM_BUFS; i++) push_random_buffer();
      wait_drained();
    end

    if (expected_results.size() != 0) mismatches++;
    $display("Checked %0d results from %0d header buffers (%0d cut short), %0d input bytes",
             results_checked, buffers_sent, short_sent, bytes_taken);
    $display("Covered %0d register settings and one %0d-cycle output hold-off under load",
             settings_used, HOLD_CYCLES);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
